// File: rtl/b64d_pkg.sv
// Shared types, character constants and decode functions for the base64 decoder.
package b64d_pkg;

  // Character codes of the alphabet boundaries and special characters
  localparam logic [7:0] CHAR_UP_A   = 8'd65;   // 'A'
  localparam logic [7:0] CHAR_UP_Z   = 8'd90;   // 'Z'
  localparam logic [7:0] CHAR_LO_A   = 8'd97;   // 'a'
  localparam logic [7:0] CHAR_LO_Z   = 8'd122;  // 'z'
  localparam logic [7:0] CHAR_ZERO   = 8'd48;   // '0'
  localparam logic [7:0] CHAR_NINE   = 8'd57;   // '9'
  localparam logic [7:0] CHAR_PLUS   = 8'd43;   // '+'
  localparam logic [7:0] CHAR_SLASH  = 8'd47;   // '/'
  localparam logic [7:0] CHAR_PAD    = 8'd61;   // '='
  localparam logic [7:0] CHAR_NL     = 8'd10;   // newline

  // Alphabet offsets
  localparam logic [5:0] OFS_LOWER   = 6'd26;
  localparam logic [5:0] OFS_DIGIT   = 6'd52;
  localparam logic [5:0] VAL_PLUS    = 6'd62;
  localparam logic [5:0] VAL_SLASH   = 6'd63;

  // Character classes
  localparam logic [1:0] CLS_DATA    = 2'd0;
  localparam logic [1:0] CLS_PAD     = 2'd1;
  localparam logic [1:0] CLS_NEWLINE = 2'd2;
  localparam logic [1:0] CLS_BAD     = 2'd3;

  // Job kinds passed from front to back
  localparam logic [1:0] KIND_BYTES  = 2'd0;
  localparam logic [1:0] KIND_BAD    = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // Register map (byte address divided by four)
  localparam logic REG_REPAIR_MODE   = 1'b0;

  // Job queue depth default
  localparam int QUEUE_DEPTH_DEF     = 4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } b64d_in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       bad_char;
    logic       stream_end;
    logic       last_of_run;
  } b64d_out_t;

  // One unit of work for the back end: 1 to 3 results
  typedef struct packed {
    logic [23:0] group;
    logic [1:0]  nres;
    logic [1:0]  kind;
    logic        fin;
  } b64d_job_t;

  function automatic logic [1:0] b64d_class(input logic [7:0] c);
    logic [1:0] cls;
    cls = CLS_BAD;
    unique case (c) inside
      [CHAR_UP_A:CHAR_UP_Z],
      [CHAR_LO_A:CHAR_LO_Z],
      [CHAR_ZERO:CHAR_NINE],
      CHAR_PLUS, CHAR_SLASH:  cls = CLS_DATA;
      CHAR_PAD:               cls = CLS_PAD;
      CHAR_NL:                cls = CLS_NEWLINE;
      default:                cls = CLS_BAD;
    endcase
    return cls;
  endfunction

  function automatic logic [5:0] b64d_value(input logic [7:0] c);
    logic [7:0] diff;
    logic [5:0] v;
    diff = 8'd0;
    v    = 6'd0;
    unique case (c) inside
      [CHAR_UP_A:CHAR_UP_Z]: begin
        diff = c - CHAR_UP_A;
        v    = diff[5:0];
      end
      [CHAR_LO_A:CHAR_LO_Z]: begin
        diff = c - CHAR_LO_A;
        v    = diff[5:0] + OFS_LOWER;
      end
      [CHAR_ZERO:CHAR_NINE]: begin
        diff = c - CHAR_ZERO;
        v    = diff[5:0] + OFS_DIGIT;
      end
      CHAR_PLUS:  v = VAL_PLUS;
      CHAR_SLASH: v = VAL_SLASH;
      default:    v = 6'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/base64_decoder_unit.sv
// Base64 decoder top level: front end, job queue, back end and register port.
//
// Input channel (in_valid/in_ready/in_data) takes one ASCII character per
// transfer, or an end-of-input marker. Output channel (out_valid/out_ready/
// out_data) gives decoded bytes, error results and end markers, each with
// last_of_run on the final result caused by one input transfer.
// One register, repair_mode, sits at byte address 0 of the APB-style port.
//
// Throughput: one character per cycle while the job queue has room. The
// back end emits one result per cycle while out_ready is high, so a complete
// group (up to three bytes) drains while the next group is still being
// collected. in_ready drops only when the job queue (QUEUE_DEPTH entries)
// is full. A result passes two registers: the queue entry, written when the
// transfer is accepted, and the output register, loaded from the queue head
// when it is free; further bytes of a group follow one per cycle.
// When out_ready is low the output register holds its result; jobs pile up
// in the queue, and once it is full in_ready goes low.
// Reset (rst_n low, synchronous) clears the group being built, empties the
// queue, drops out_valid and sets repair_mode to 0.
module base64_decoder_unit
  import b64d_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  b64d_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output b64d_out_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic      repair_r;
  logic      cfg_wr;
  logic      push, pop, q_full, q_empty;
  b64d_job_t push_job, head;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_REPAIR_MODE);
  assign prdata = (paddr[2] == REG_REPAIR_MODE) ? {31'd0, repair_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repair_r <= 1'b0;
    end else if (cfg_wr) begin
      repair_r <= pwdata[0];
    end
  end

  b64d_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .repair_mode (repair_r),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/b64d_front.sv
// Front end: accepts characters, builds 24-bit groups and issues jobs to the queue.
module b64d_front
  import b64d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  b64d_in_t  in_data,
  input  logic      repair_mode,
  input  logic      q_full,
  output logic      push,
  output b64d_job_t push_job
);

  logic [23:0] group_r, group_nxt;
  logic [1:0]  slots_r, slots_nxt;
  logic [1:0]  chars_r, chars_nxt;

  logic        fire;
  logic [1:0]  cls;
  logic [5:0]  val;
  logic        is_data;
  logic [23:0] placed;
  logic [23:0] group_upd;
  logic [2:0]  chars_upd;
  logic [2:0]  cnt_full;
  logic [1:0]  cnt_end;

  assign in_ready = !q_full;
  assign fire     = in_valid && !q_full;

  // Character classification
  assign cls     = b64d_class(in_data.char_code);
  assign val     = b64d_value(in_data.char_code);
  assign is_data = (cls == CLS_DATA);

  // Slot placement, most significant slot first
  always_comb begin
    placed = 24'd0;
    case (slots_r)
      2'd0:    placed = {val, 18'd0};
      2'd1:    placed = {6'd0, val, 12'd0};
      2'd2:    placed = {12'd0, val, 6'd0};
      default: placed = {18'd0, val};
    endcase
  end

  assign group_upd = group_r | (is_data ? placed : 24'd0);
  assign chars_upd = {1'b0, chars_r} + {2'd0, is_data};
  assign cnt_full  = (chars_upd == 3'd0) ? 3'd0 : chars_upd - 3'd1;
  assign cnt_end   = (chars_r == 2'd0) ? 2'd0 : chars_r - 2'd1;

  // Group state update and job issue
  always_comb begin
    group_nxt = group_r;
    slots_nxt = slots_r;
    chars_nxt = chars_r;
    push      = 1'b0;
    push_job  = '0;
    if (fire) begin
      if (in_data.end_of_input) begin
        push      = 1'b1;
        group_nxt = 24'd0;
        slots_nxt = 2'd0;
        chars_nxt = 2'd0;
        if (cnt_end != 2'd0) begin
          push_job.group = group_r;
          push_job.nres  = cnt_end;
          push_job.kind  = KIND_BYTES;
          push_job.fin   = 1'b1;
        end else begin
          push_job.nres  = 2'd1;
          push_job.kind  = KIND_END;
          push_job.fin   = 1'b1;
        end
      end else begin
        case (cls)
          CLS_DATA, CLS_PAD: begin
            if (slots_r == 2'd3) begin
              group_nxt = 24'd0;
              slots_nxt = 2'd0;
              chars_nxt = 2'd0;
              if (cnt_full != 3'd0) begin
                push           = 1'b1;
                push_job.group = group_upd;
                push_job.nres  = cnt_full[1:0];
                push_job.kind  = KIND_BYTES;
              end
            end else begin
              group_nxt = group_upd;
              slots_nxt = slots_r + 2'd1;
              chars_nxt = chars_upd[1:0];
            end
          end
          CLS_BAD: begin
            if (!repair_mode) begin
              push          = 1'b1;
              push_job.nres = 2'd1;
              push_job.kind = KIND_BAD;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r <= 24'd0;
      slots_r <= 2'd0;
      chars_r <= 2'd0;
    end else begin
      group_r <= group_nxt;
      slots_r <= slots_nxt;
      chars_r <= chars_nxt;
    end
  end

endmodule

// File: rtl/b64d_queue.sv
// Short job queue between front and back end, held in flip-flops.
module b64d_queue
  import b64d_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  b64d_job_t push_job,
  input  logic      pop,
  output b64d_job_t head,
  output logic      empty,
  output logic      full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b64d_job_t     mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == FULL_CNT);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/b64d_back.sv
// Back end: expands queued jobs into result items through an output register.
module b64d_back
  import b64d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  b64d_job_t head,
  input  logic      q_empty,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output b64d_out_t out_data
);

  logic [1:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  b64d_out_t  out_data_r;
  b64d_out_t  res;
  logic       load;
  logic       last;
  logic [7:0] byte_sel;

  assign load = (!out_valid_r || out_ready) && !q_empty;
  assign last = (k_r == head.nres - 2'd1);

  // Byte select, most significant first
  always_comb begin
    case (k_r)
      2'd0:    byte_sel = head.group[23:16];
      2'd1:    byte_sel = head.group[15:8];
      default: byte_sel = head.group[7:0];
    endcase
  end

  // Result for the current position in the job
  always_comb begin
    res = '0;
    unique case (head.kind)
      KIND_BYTES: begin
        res.data_byte   = byte_sel;
        res.has_byte    = 1'b1;
        res.stream_end  = head.fin && last;
        res.last_of_run = last;
      end
      KIND_BAD: begin
        res.bad_char    = 1'b1;
        res.last_of_run = 1'b1;
      end
      KIND_END: begin
        res.stream_end  = 1'b1;
        res.last_of_run = 1'b1;
      end
      default: res = '0;
    endcase
  end

  assign pop           = load && last;
  assign k_nxt         = load ? (last ? 2'd0 : k_r + 2'd1) : k_r;
  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/b64d_checker.sv
// Port-level checks for the base64 decoder and the bind that attaches them.
module b64d_checker
  import b64d_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input b64d_out_t out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output result changed while stalled");

  // Error results carry no byte and close their run
  a_bad_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_char |->
      !out_data.has_byte && out_data.data_byte == 8'd0 &&
      out_data.last_of_run && !out_data.stream_end)
    else $error("malformed error result");

  // Stream end is always the last result of its run
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_end |-> out_data.last_of_run)
    else $error("stream end on a non-final result");

  // Nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind base64_decoder_unit b64d_checker u_b64d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
